@@ rtl/mahf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the MAC address hash filter: widths, CRC constants, XOR masks and the update type.
package mahf_pkg;

	localparam int AddrW       = 48;
	localparam int TableBits   = 64;
	localparam int PosW        = 6;
	localparam int HashIdxW    = 6;
	localparam int HashBitsMax = 8;
	localparam int CrcW        = 32;

	localparam logic [CrcW-1:0] CrcPoly = 32'hEDB8_8320;
	localparam logic [CrcW-1:0] CrcInit = 32'hFFFF_FFFF;

	typedef logic [CrcW-1:0][AddrW-1:0] crc_mask_t;

	// Table update carried from the pipeline control to the table registers.
	typedef struct packed {
		logic            load;
		logic            start;
		logic            used;
		logic            group;
		logic [PosW-1:0] pos;
	} tbl_upd_t;

	// Bit-serial reflected CRC over the six address bytes, first wire byte first.
	// It is only ever evaluated on constants, to build the masks below.
	function automatic logic [CrcW-1:0] crc48(input logic [AddrW-1:0] addr,
			input logic [CrcW-1:0] init);
		logic [CrcW-1:0] crc;
		crc = init;
		for (int b = 0; b < AddrW / 8; b++) begin
			crc[7:0] = crc[7:0] ^ addr[AddrW-1-8*b -: 8];
			for (int j = 0; j < 8; j++) begin
				crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
			end
		end
		return crc;
	endfunction

	// Row j gives the address bits whose parity feeds CRC bit j.
	function automatic crc_mask_t crc_masks();
		crc_mask_t       m;
		logic [CrcW-1:0] col;
		m = '0;
		for (int k = 0; k < AddrW; k++) begin
			col = crc48(AddrW'(1) << k, '0);
			for (int j = 0; j < CrcW; j++) begin
				m[j][k] = col[j];
			end
		end
		return m;
	endfunction

	localparam crc_mask_t       CrcMask   = crc_masks();
	localparam logic [CrcW-1:0] CrcPreset = crc48('0, CrcInit);

endpackage

@@ rtl/mahf_in_if.sv @@
`timescale 1ns / 1ps
// Interface for the address entry channel.
interface mahf_in_if;
	import mahf_pkg::*;

	logic             valid;
	logic             ready;
	logic [AddrW-1:0] mac_addr;
	logic             in_use;
	logic             start_list;

	modport source (output valid, mac_addr, in_use, start_list, input ready);
	modport sink (input valid, mac_addr, in_use, start_list, output ready);
endinterface

@@ rtl/mahf_out_if.sv @@
`timescale 1ns / 1ps
// Interface for the hash result channel.
interface mahf_out_if;
	import mahf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [HashIdxW-1:0]  hash_index;
	logic                 is_group;
	logic [TableBits-1:0] unicast_table;
	logic [TableBits-1:0] multicast_table;

	modport source (output valid, hash_index, is_group, unicast_table, multicast_table,
		input ready);
	modport sink (input valid, hash_index, is_group, unicast_table, multicast_table,
		output ready);
endinterface

@@ rtl/mac_address_hash_filter_core.sv @@
`timescale 1ns / 1ps
// Top level of the MAC address hash filter: input stage, hash network, tables, result stage.
//
//  channel | dir | word carries
//  --------+-----+-----------------------------------------------------------
//  entry   | in  | mac_addr (48), in_use, start_list
//  result  | out | hash_index (6), is_group, unicast_table (64), multicast_table (64)
//
// Each word is registered in the input stage and then moves into the result stage, so one
// word is taken in every cycle while results are taken.
// The CRC is a flat XOR network of constant masks, one parity tree per index bit, which sets
// the path from the input stage to the table and result registers.
// Reset clears both tables and the valid flags of both stages.
// When the result is not taken, the input stage still takes one word and then holds it.
module mac_address_hash_filter_core #(
	parameter int HASH_BITS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	mahf_in_if.sink     entry,
	mahf_out_if.source  result
);
	import mahf_pkg::*;

	// Input stage.
	logic             valid_s1;
	logic [AddrW-1:0] addr_s1;
	logic             in_use_s1;
	logic             start_s1;

	// Result stage; the tables themselves double as its table fields.
	logic                out_valid_q;
	logic [HashIdxW-1:0] hash_index_q;
	logic                is_group_q;

	logic                 advance;
	logic [HASH_BITS-1:0] idx;
	logic [HashBitsMax-1:0] idx_ext;
	logic                 group;
	tbl_upd_t             upd;

	// The input stage moves on whenever the result stage is empty or being emptied.
	assign advance     = valid_s1 && (!out_valid_q || result.ready);
	assign entry.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (entry.ready) begin
			valid_s1 <= entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (entry.ready && entry.valid) begin
			addr_s1   <= entry.mac_addr;
			in_use_s1 <= entry.in_use;
			start_s1  <= entry.start_list;
		end
	end

	mahf_crc_hash #(
		.HASH_BITS(HASH_BITS)
	) u_hash (
		.addr (addr_s1),
		.idx  (idx),
		.group(group)
	);

	// An index narrower than six bits is zero-extended; a wider one keeps its low six bits.
	assign idx_ext = HashBitsMax'(idx);

	always_comb begin
		upd.load  = advance;
		upd.start = start_s1;
		upd.used  = in_use_s1;
		upd.group = group;
		upd.pos   = idx_ext[PosW-1:0];
	end

	mahf_tables u_tables (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.unicast_q  (result.unicast_table),
		.multicast_q(result.multicast_table)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hash_index_q <= idx_ext[HashIdxW-1:0];
			is_group_q   <= group;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.hash_index = hash_index_q;
	assign result.is_group   = is_group_q;

	// A waiting result must not see its tables change underneath it.
	a_tables_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=>
		$stable(result.unicast_table) && $stable(result.multicast_table))
		else $error("tables changed while the result was stalled");

	// A word in the input stage that cannot move on is kept for the next cycle.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(addr_s1))
		else $error("input stage dropped a waiting word");

	// Every move into the result stage leaves a valid result.
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result stage empty after a move");
endmodule

@@ rtl/mahf_crc_hash.sv @@
`timescale 1ns / 1ps
// Parallel CRC-32 XOR network giving the hash index and group flag of one address.
module mahf_crc_hash #(
	parameter int HASH_BITS = 6
) (
	input  logic [mahf_pkg::AddrW-1:0] addr,
	output logic [HASH_BITS-1:0]       idx,
	output logic                       group
);
	import mahf_pkg::*;

	// Each index bit is a preset constant XOR the parity of a masked address.
	always_comb begin
		for (int i = 0; i < HASH_BITS; i++) begin
			idx[i] = CrcPreset[CrcW-HASH_BITS+i] ^ (^(addr & CrcMask[CrcW-HASH_BITS+i]));
		end
	end

	assign group = addr[AddrW-8];
endmodule

@@ rtl/mahf_tables.sv @@
`timescale 1ns / 1ps
// Unicast and multicast hash table registers with clear and set logic.
module mahf_tables (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mahf_pkg::tbl_upd_t             upd,
	output logic [mahf_pkg::TableBits-1:0] unicast_q,
	output logic [mahf_pkg::TableBits-1:0] multicast_q
);
	import mahf_pkg::*;

	logic [TableBits-1:0] uni_base, mc_base, set_bit, uni_nxt, mc_nxt;

	always_comb begin
		uni_base = upd.start ? '0 : unicast_q;
		mc_base  = upd.start ? '0 : multicast_q;
		set_bit  = TableBits'(1) << upd.pos;
		uni_nxt  = uni_base | ((upd.used && !upd.group) ? set_bit : '0);
		mc_nxt   = mc_base | ((upd.used && upd.group) ? set_bit : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unicast_q   <= '0;
			multicast_q <= '0;
		end else if (upd.load) begin
			unicast_q   <= uni_nxt;
			multicast_q <= mc_nxt;
		end
	end

	// Without a start flag the tables only ever gain bits.
	a_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		upd.load && !upd.start |=>
		((unicast_q & $past(unicast_q)) == $past(unicast_q)) &&
		((multicast_q & $past(multicast_q)) == $past(multicast_q)))
		else $error("hash table lost a bit without a start flag");

	// A start with an unused entry leaves both tables empty.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		upd.load && upd.start && !upd.used |=> unicast_q == '0 && multicast_q == '0)
		else $error("start flag did not clear the tables");
endmodule
